### hdl/asfr_pkg.sv
// Shared types and constants for the addressed serial frame responder.
package asfr_pkg;

    localparam logic [1:0] MODE_RX_BYTE   = 2'd0;
    localparam logic [1:0] MODE_TICK      = 2'd1;
    localparam logic [1:0] MODE_RESP_BYTE = 2'd2;
    localparam logic [1:0] MODE_RESP_LEN  = 2'd3;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_FRAME   = 2'd1;
    localparam logic [1:0] KIND_TX_BYTE = 2'd2;
    localparam logic [1:0] KIND_TX_EN   = 2'd3;

    localparam logic [2:0] RX_DIRTY  = 3'd0;
    localparam logic [2:0] RX_READY  = 3'd1;
    localparam logic [2:0] RX_HEADER = 3'd2;
    localparam logic [2:0] RX_DATA   = 3'd3;
    localparam logic [2:0] RX_CHECK  = 3'd4;

    localparam logic [1:0] TX_IDLE = 2'd0;
    localparam logic [1:0] TX_WAIT = 2'd1;
    localparam logic [1:0] TX_HOLD = 2'd2;

    localparam logic [2:0] CFG_NODE_ADDR = 3'd0;
    localparam logic [2:0] CFG_IDLE_GAP  = 3'd1;
    localparam logic [2:0] CFG_TIMEOUT   = 3'd2;
    localparam logic [2:0] CFG_DELAY     = 3'd3;
    localparam logic [2:0] CFG_BYTE_TIME = 3'd4;
    localparam logic [2:0] CFG_TX_PAD    = 3'd5;

    localparam logic [7:0] START_CMD   = 8'h45;
    localparam logic [7:0] START_REPLY = 8'h65;
    localparam logic [15:0] TIMER_MAX  = 16'hFFFF;

    // One result beat
    typedef struct packed {
        logic       last;
        logic [7:0] value;
        logic [1:0] kind;
    } result_t;

    // Memory request from the sequencer
    typedef struct packed {
        logic       wr_en;
        logic       wr_sel;   // 0 payload store, 1 response store
        logic [3:0] wr_addr;
        logic [7:0] wr_data;
        logic       rd_sel;
        logic [3:0] rd_addr;
    } mem_req_t;

endpackage

### hdl/asfr_store.sv
// Payload and response byte stores with a registered synchronous read.
module asfr_store (
    input  logic                aclk,
    input  asfr_pkg::mem_req_t  req,
    output logic [7:0]          rd_data
);
    logic [7:0] payload_mem [16];
    logic [7:0] response_mem [16];

    always_ff @(posedge aclk) begin
        if (req.wr_en && !req.wr_sel) begin
            payload_mem[req.wr_addr] <= req.wr_data;
        end
        if (req.wr_en && req.wr_sel) begin
            response_mem[req.wr_addr] <= req.wr_data;
        end
        rd_data <= req.rd_sel ? response_mem[req.rd_addr] : payload_mem[req.rd_addr];
    end
endmodule

### hdl/asfr_ctrl.sv
// Receive and transmit sequencer: frame parsing, timers and result streaming.
module asfr_ctrl #(
    parameter int MAX_PAYLOAD = 15
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          in_mode,
    input  logic [7:0]          in_byte,
    input  logic [3:0]          in_index,
    input  logic [3:0]          in_length,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_addr,
    input  logic [15:0]         cfg_data,
    output asfr_pkg::mem_req_t  mem_req,
    input  logic [7:0]          mem_rd_data,
    output logic                out_valid,
    input  logic                out_ready,
    output asfr_pkg::result_t   out_data
);
    localparam logic [3:0] MaxLen = 4'(MAX_PAYLOAD);

    // Sequencer codes
    localparam logic [2:0] SQ_IDLE   = 3'd0;
    localparam logic [2:0] SQ_RDPAY  = 3'd1;  // stream payload bytes
    localparam logic [2:0] SQ_FRAME  = 3'd2;  // frame delivered beat
    localparam logic [2:0] SQ_TXHEAD = 3'd3;  // enable, 'e', header
    localparam logic [2:0] SQ_TXBODY = 3'd4;  // response bytes
    localparam logic [2:0] SQ_TXSUM  = 3'd5;
    localparam logic [2:0] SQ_TXOFF  = 3'd6;

    logic [3:0]  node_addr_reg;
    logic [15:0] idle_gap_reg, timeout_reg, delay_reg;
    logic [7:0]  byte_time_reg, pad_reg;

    logic [2:0]  rx_phase_reg;
    logic [4:0]  byte_count_reg;
    logic [7:0]  sum_reg;
    logic        is_cmd_reg;
    logic [3:0]  frame_addr_reg, frame_len_reg;
    logic [15:0] silence_reg, frame_timer_reg, tx_timer_reg, hold_reg;
    logic [1:0]  tx_phase_reg;
    logic [3:0]  resp_len_reg;

    logic [2:0]  sq_reg;
    logic [1:0]  pos_reg;        // beats issued in the reply head
    logic [3:0]  rd_ptr_reg;
    logic        rd_pend_reg;    // read issued last cycle
    logic [7:0]  tx_sum_reg;
    asfr_pkg::result_t ob_reg;
    logic        ob_valid_reg;

    // Compute result beat generation using a registered output slot.
    wire ob_free = !ob_valid_reg || out_ready;
    wire ob_load = ob_free && (((sq_reg inside {SQ_RDPAY, SQ_TXBODY}) && rd_pend_reg)
                               || (sq_reg inside {SQ_FRAME, SQ_TXHEAD, SQ_TXSUM, SQ_TXOFF}));
    assign out_valid = ob_valid_reg;
    assign out_data  = ob_reg;
    assign in_ready  = (sq_reg == SQ_IDLE);

    wire accept = in_valid && in_ready;
    wire [15:0] sil_inc = (silence_reg == asfr_pkg::TIMER_MAX) ? silence_reg
                                                               : silence_reg + 16'd1;
    wire [15:0] fr_inc  = (frame_timer_reg == asfr_pkg::TIMER_MAX) ? frame_timer_reg
                                                                   : frame_timer_reg + 16'd1;
    wire [15:0] tx_inc  = (tx_timer_reg == asfr_pkg::TIMER_MAX) ? tx_timer_reg
                                                                : tx_timer_reg + 16'd1;
    wire [7:0]  hdr     = {node_addr_reg, resp_len_reg};
    wire [12:0] hold_prod = {5'd0, byte_time_reg} * ({9'd0, resp_len_reg} + 13'd3);

    always_comb begin
        mem_req = '0;
        mem_req.rd_sel  = (sq_reg == SQ_TXBODY) || (sq_reg == SQ_TXHEAD);
        mem_req.rd_addr = rd_ptr_reg;
        if (accept && in_mode == asfr_pkg::MODE_RESP_BYTE) begin
            mem_req.wr_en = 1'b1; mem_req.wr_sel = 1'b1;
            mem_req.wr_addr = in_index; mem_req.wr_data = in_byte;
        end else if (accept && in_mode == asfr_pkg::MODE_RX_BYTE
                     && tx_phase_reg == asfr_pkg::TX_IDLE
                     && rx_phase_reg == asfr_pkg::RX_DATA) begin
            mem_req.wr_en = 1'b1; mem_req.wr_sel = 1'b0;
            mem_req.wr_addr = byte_count_reg[3:0]; mem_req.wr_data = in_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_addr_reg <= '0; idle_gap_reg <= 16'd5000; timeout_reg <= 16'd4000;
            delay_reg <= 16'd750; byte_time_reg <= 8'd87; pad_reg <= 8'd80;
            rx_phase_reg <= asfr_pkg::RX_DIRTY; byte_count_reg <= '0; sum_reg <= '0;
            is_cmd_reg <= 1'b0; frame_addr_reg <= '0; frame_len_reg <= '0;
            silence_reg <= '0; frame_timer_reg <= '0; tx_timer_reg <= '0; hold_reg <= '0;
            tx_phase_reg <= asfr_pkg::TX_IDLE; resp_len_reg <= '0;
            sq_reg <= SQ_IDLE; pos_reg <= '0; rd_ptr_reg <= '0; rd_pend_reg <= 1'b0;
            tx_sum_reg <= '0; ob_valid_reg <= 1'b0; ob_reg <= '0;
        end else begin
            if (ob_load) ob_valid_reg <= 1'b1;
            else if (out_ready) ob_valid_reg <= 1'b0;
            if (cfg_we) begin
                case (cfg_addr)
                    asfr_pkg::CFG_NODE_ADDR: node_addr_reg <= cfg_data[3:0];
                    asfr_pkg::CFG_IDLE_GAP:  idle_gap_reg  <= cfg_data;
                    asfr_pkg::CFG_TIMEOUT:   timeout_reg   <= cfg_data;
                    asfr_pkg::CFG_DELAY:     delay_reg     <= cfg_data;
                    asfr_pkg::CFG_BYTE_TIME: byte_time_reg <= cfg_data[7:0];
                    asfr_pkg::CFG_TX_PAD:    pad_reg       <= cfg_data[7:0];
                    default: ;
                endcase
            end
            case (sq_reg)
                SQ_IDLE: begin
                    if (accept) begin
                        case (in_mode)
                            asfr_pkg::MODE_RX_BYTE: begin
                                if (tx_phase_reg == asfr_pkg::TX_IDLE) begin
                                    silence_reg <= '0;
                                    case (rx_phase_reg)
                                        asfr_pkg::RX_READY: begin
                                            if (in_byte != asfr_pkg::START_CMD
                                                && in_byte != asfr_pkg::START_REPLY) begin
                                                rx_phase_reg <= asfr_pkg::RX_DIRTY;
                                            end else begin
                                                is_cmd_reg <= (in_byte == asfr_pkg::START_CMD);
                                                frame_timer_reg <= '0;
                                                sum_reg <= in_byte;
                                                rx_phase_reg <= asfr_pkg::RX_HEADER;
                                            end
                                        end
                                        asfr_pkg::RX_HEADER: begin
                                            frame_addr_reg <= in_byte[7:4];
                                            frame_len_reg <= in_byte[3:0];
                                            sum_reg <= sum_reg + in_byte;
                                            byte_count_reg <= '0;
                                            if (in_byte[3:0] > MaxLen)
                                                rx_phase_reg <= asfr_pkg::RX_DIRTY;
                                            else if (in_byte[3:0] == 4'd0)
                                                rx_phase_reg <= asfr_pkg::RX_CHECK;
                                            else
                                                rx_phase_reg <= asfr_pkg::RX_DATA;
                                        end
                                        asfr_pkg::RX_DATA: begin
                                            byte_count_reg <= byte_count_reg + 5'd1;
                                            sum_reg <= sum_reg + in_byte;
                                            if (byte_count_reg + 5'd1 >= {1'b0, frame_len_reg})
                                                rx_phase_reg <= asfr_pkg::RX_CHECK;
                                        end
                                        asfr_pkg::RX_CHECK: begin
                                            if (in_byte != sum_reg) begin
                                                rx_phase_reg <= asfr_pkg::RX_DIRTY;
                                            end else begin
                                                rx_phase_reg <= asfr_pkg::RX_READY;
                                                if (is_cmd_reg
                                                    && frame_addr_reg == node_addr_reg) begin
                                                    tx_phase_reg <= asfr_pkg::TX_WAIT;
                                                    tx_timer_reg <= '0;
                                                    rd_ptr_reg <= '0;
                                                    rd_pend_reg <= 1'b0;
                                                    sq_reg <= (frame_len_reg == 4'd0) ? SQ_FRAME
                                                                                        : SQ_RDPAY;
                                                end
                                            end
                                        end
                                        default: ;
                                    endcase
                                end
                            end
                            asfr_pkg::MODE_TICK: begin
                                silence_reg <= sil_inc;
                                if (rx_phase_reg == asfr_pkg::RX_DIRTY) begin
                                    if (sil_inc > idle_gap_reg || sil_inc == asfr_pkg::TIMER_MAX)
                                        rx_phase_reg <= asfr_pkg::RX_READY;
                                end else if (rx_phase_reg != asfr_pkg::RX_READY) begin
                                    frame_timer_reg <= fr_inc;
                                    if (fr_inc > timeout_reg || fr_inc == asfr_pkg::TIMER_MAX)
                                        rx_phase_reg <= asfr_pkg::RX_DIRTY;
                                end
                                if (tx_phase_reg == asfr_pkg::TX_WAIT) begin
                                    if (tx_inc >= delay_reg) begin
                                        hold_reg <= 16'(hold_prod) + 16'(pad_reg);
                                        tx_timer_reg <= '0;
                                        tx_phase_reg <= asfr_pkg::TX_HOLD;
                                        tx_sum_reg <= asfr_pkg::START_REPLY + hdr;
                                        pos_reg <= '0;
                                        rd_ptr_reg <= '0;
                                        rd_pend_reg <= 1'b0;
                                        sq_reg <= SQ_TXHEAD;
                                    end else begin
                                        tx_timer_reg <= tx_inc;
                                    end
                                end else if (tx_phase_reg == asfr_pkg::TX_HOLD) begin
                                    if (tx_inc >= hold_reg) begin
                                        tx_phase_reg <= asfr_pkg::TX_IDLE;
                                        tx_timer_reg <= '0;
                                        sq_reg <= SQ_TXOFF;
                                    end else begin
                                        tx_timer_reg <= tx_inc;
                                    end
                                end
                            end
                            asfr_pkg::MODE_RESP_BYTE: ;
                            default: resp_len_reg <= (in_length > MaxLen) ? MaxLen : in_length;
                        endcase
                    end
                end
                SQ_RDPAY: begin
                    // Issue read, emit the word when it returns.
                    if (!rd_pend_reg) begin
                        rd_pend_reg <= 1'b1;
                    end else if (ob_free) begin
                        ob_reg <= '{last: 1'b0, value: mem_rd_data, kind: asfr_pkg::KIND_PAYLOAD};
                        rd_pend_reg <= 1'b0;
                        rd_ptr_reg <= rd_ptr_reg + 4'd1;
                        if (rd_ptr_reg + 4'd1 == frame_len_reg) sq_reg <= SQ_FRAME;
                    end
                end
                SQ_FRAME: begin
                    if (ob_free) begin
                        ob_reg <= '{last: 1'b1, value: {4'd0, frame_len_reg},
                                    kind: asfr_pkg::KIND_FRAME};
                        sq_reg <= SQ_IDLE;
                    end
                end
                SQ_TXHEAD: begin
                    if (ob_free) begin
                        pos_reg <= pos_reg + 2'd1;
                        case (pos_reg)
                            2'd0: ob_reg <= '{last: 1'b0, value: 8'd1, kind: asfr_pkg::KIND_TX_EN};
                            2'd1: ob_reg <= '{last: 1'b0, value: asfr_pkg::START_REPLY,
                                              kind: asfr_pkg::KIND_TX_BYTE};
                            default: begin
                                ob_reg <= '{last: 1'b0, value: hdr, kind: asfr_pkg::KIND_TX_BYTE};
                                sq_reg <= (resp_len_reg == 4'd0) ? SQ_TXSUM : SQ_TXBODY;
                            end
                        endcase
                    end
                end
                SQ_TXBODY: begin
                    if (!rd_pend_reg) begin
                        rd_pend_reg <= 1'b1;
                    end else if (ob_free) begin
                        ob_reg <= '{last: 1'b0, value: mem_rd_data, kind: asfr_pkg::KIND_TX_BYTE};
                        tx_sum_reg <= tx_sum_reg + mem_rd_data;
                        rd_pend_reg <= 1'b0;
                        rd_ptr_reg <= rd_ptr_reg + 4'd1;
                        if (rd_ptr_reg + 4'd1 == resp_len_reg) sq_reg <= SQ_TXSUM;
                    end
                end
                SQ_TXSUM: begin
                    if (ob_free) begin
                        ob_reg <= '{last: 1'b1, value: tx_sum_reg, kind: asfr_pkg::KIND_TX_BYTE};
                        sq_reg <= SQ_IDLE;
                    end
                end
                SQ_TXOFF: begin
                    if (ob_free) begin
                        ob_reg <= '{last: 1'b1, value: 8'd0, kind: asfr_pkg::KIND_TX_EN};
                        sq_reg <= SQ_IDLE;
                    end
                end
                default: sq_reg <= SQ_IDLE;
            endcase
        end
    end

    // A payload read never runs while a new payload byte is written.
    a_no_wr_in_stream: assert property (@(posedge aclk) disable iff (!aresetn)
        (sq_reg != SQ_IDLE) |-> !mem_req.wr_en)
        else $error("store written during result stream");
    // Outstanding beat holds until taken.
    a_beat_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("result beat dropped");
    // Transmit is active whenever a reply is being streamed.
    a_tx_active: assert property (@(posedge aclk) disable iff (!aresetn)
        (sq_reg == SQ_TXBODY || sq_reg == SQ_TXSUM) |-> (tx_phase_reg == asfr_pkg::TX_HOLD))
        else $error("reply streamed outside hold phase");
endmodule

### hdl/addressed_serial_frame_responder_top.sv
// Top level of the addressed serial frame responder.
//
// Input channel (s_axis_*): one beat per event: a received bus byte, a
// one-microsecond tick, a response byte write or a response length commit;
// tuser carries the event mode, tdata the byte, index and length.
// Result channel (m_axis_*): payload bytes, frame-delivered marks, transmit
// bytes and transmit enable levels; tuser carries the kind, tdata the value,
// tlast marks the final beat of an input.
// Configuration: cfg_we/cfg_addr/cfg_wdata write one register per edge;
// write only while no input is in flight.
//
// An input that produces no results leaves s_axis_tready high.
// An input that produces results holds s_axis_tready low until its last
// beat is loaded into the output register. Each byte read from the
// payload or response store is emitted from the store's registered read
// data before the next read is issued; the other beats need no read.
// The output register lets the next input be taken while the last beat
// still waits. A stalled receiver simply stretches the sequence; nothing
// is lost. Reset (aresetn low, synchronous) restores the register defaults,
// puts the receiver in the dirty state and the transmitter idle; the byte
// stores are not cleared and hold undefined data until written.
module addressed_serial_frame_responder_top #(
    parameter int MAX_PAYLOAD = 15
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // byte_value[7:0], index[11:8], length[15:12]
    input  logic [1:0]  s_axis_tuser,   // mode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // value[7:0]
    output logic [1:0]  m_axis_tuser,   // kind[1:0]
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);
    asfr_pkg::mem_req_t mem_req;
    asfr_pkg::result_t  res;
    logic [7:0]         rd_data;

    asfr_store u_store (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    asfr_ctrl #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_mode     (s_axis_tuser),
        .in_byte     (s_axis_tdata[7:0]),
        .in_index    (s_axis_tdata[11:8]),
        .in_length   (s_axis_tdata[15:12]),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_data    (cfg_wdata),
        .mem_req     (mem_req),
        .mem_rd_data (rd_data),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_data    (res)
    );

    assign m_axis_tdata = res.value;
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last;
endmodule
